/* rtl/gmq_pkg.sv */
// Shared constants, types and helpers for the queen-contiguity Moran's I block.
`default_nettype none

package gmq_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 1;
    localparam int PIX_W    = 16;
    localparam int S_W      = 28;
    localparam int Q_W      = 43;
    localparam int P_W      = 47;
    localparam int T_W      = 32;
    localparam int W_W      = 16;
    localparam int N_W      = 13;
    localparam int FRAME_W  = 16;
    localparam int NSUM_W   = PIX_W + 2;
    localparam int PP_W     = PIX_W + NSUM_W;
    localparam int PQ_W     = 2 * PIX_W;
    localparam int K_W      = 3;
    localparam int BIG_W    = 80;
    localparam int MB_W     = 32;
    localparam int FRAC_W   = 16;
    localparam int DIV_W    = BIG_W + FRAC_W;
    localparam int RES_W    = 32;
    localparam int QUO_W    = RES_W + 1;

    localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'd1;

    localparam logic [RES_W-1:0] RES_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [S_W-1:0] s;
        logic [Q_W-1:0]        q;
        logic signed [P_W-1:0] p;
        logic signed [T_W-1:0] t;
        logic [W_W-1:0]        w;
        logic [N_W-1:0]        n;
    } gmq_sums_t;

    // A count of zero behaves as one, anything above the maximum as the maximum.
    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = CFG_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/grid_moran_i_queen.sv */
// Top level of the queen-contiguity Moran's I block.
`default_nettype none

// Cells of a frame arrive in row-major order, one beat each; every cell goes through
// line memory read, neighbor multiply and accumulate into the frame sums, and no new
// cell is taken until the last one is through. After the last cell of a frame, a
// shared shift-and-add multiplier (eight products) and a one-bit-per-cycle divider
// produce the Q15.16 result, and no cell is taken until it is done; a degenerate
// frame finishes after the first two products. The line memory needs no clearing
// after reset. Writing row_count or col_count discards any partial frame; write
// them only while idle.
module grid_moran_i_queen
    import gmq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    pixel_valid,
    output logic                         pixel_stall,
    input  wire logic signed [PIX_W-1:0] pixel,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic signed [RES_W-1:0]      moran_i,
    output logic                         undefined_flag,
    output logic [FRAME_W-1:0]           frame_index
);

    logic        fin_start, fin_busy, fin_done, fin_flag, out_free, load;
    gmq_sums_t   fin_sums;
    logic [RES_W-1:0] fin_moran;

    logic               result_valid_reg;
    logic [FRAME_W-1:0] frame_count_reg;
    logic [RES_W-1:0]   moran_reg;
    logic               flag_reg;
    logic [FRAME_W-1:0] index_reg;

    gmq_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .fin_start   (fin_start),
        .fin_sums    (fin_sums),
        .fin_busy    (fin_busy)
    );

    gmq_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fin_start),
        .sums     (fin_sums),
        .out_free (out_free),
        .busy     (fin_busy),
        .done     (fin_done),
        .moran    (fin_moran),
        .flag     (fin_flag)
    );

    assign out_free = !result_valid_reg || !result_stall;
    assign load     = fin_done && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            frame_count_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                result_valid_reg <= 1'b1;
                frame_count_reg  <= frame_count_reg + FRAME_W'(1);
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            moran_reg <= fin_moran;
            flag_reg  <= fin_flag;
            index_reg <= frame_count_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign moran_i        = $signed(moran_reg);
    assign undefined_flag = flag_reg;
    assign frame_index    = index_reg;

endmodule

`default_nettype wire

/* rtl/gmq_line_mem.sv */
// One-row line memory with one write port and two registered read ports.
`default_nettype none

module gmq_line_mem
    import gmq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [COL_W-1:0]        waddr,
    input  wire logic signed [PIX_W-1:0] wdata,
    input  wire logic [COL_W-1:0]        raddr_a,
    input  wire logic [COL_W-1:0]        raddr_b,
    output logic signed [PIX_W-1:0]      rdata_a,
    output logic signed [PIX_W-1:0]      rdata_b
);

    logic signed [PIX_W-1:0] mem [MAX_COLS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* rtl/gmq_accum.sv */
// Cell intake: line memory access, neighbor products and running frame sums.
`default_nettype none

module gmq_accum
    import gmq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic signed [PIX_W-1:0] pixel,
    input  wire logic                    pixel_valid,
    output logic                         pixel_stall,
    output logic                         fin_start,
    output gmq_sums_t                    fin_sums,
    input  wire logic                    fin_busy
);

    typedef enum logic [3:0] {
        AS_IDLE = 4'b0001,
        AS_MUL  = 4'b0010,
        AS_ACC  = 4'b0100,
        AS_WAIT = 4'b1000
    } acc_state_t;

    acc_state_t state_reg, state_next;

    logic [CFG_W-1:0] row_cnt_reg, col_cnt_reg;
    logic [COL_W-1:0] col_pos_reg;
    logic [ROW_W-1:0] row_pos_reg;
    logic signed [S_W-1:0] s_reg;
    logic [Q_W-1:0]        q_reg;
    logic signed [P_W-1:0] p_reg;
    logic signed [T_W-1:0] t_reg;
    logic [W_W-1:0]        w_reg;

    logic signed [PIX_W-1:0]  x_reg, left_reg, upleft_reg;
    logic signed [PP_W-1:0]   prod_p_reg;
    logic signed [PQ_W-1:0]   prod_q_reg;
    logic signed [NSUM_W-1:0] nsum_reg;
    logic [K_W-1:0]           k_reg;
    logic                     last_col_reg;

    logic accept;
    logic [COL_W-1:0] col_addr_b;
    logic signed [PIX_W-1:0] up_cell, upright_cell;
    logic c_gt0, r_gt0, last_col, has_ur, last_row, last_cell;
    logic signed [NSUM_W-1:0] nsum;
    logic [K_W-1:0] k_cnt;
    logic signed [PIX_W+K_W:0] kx;
    gmq_sums_t sums_next;

    assign pixel_stall = (state_reg != AS_IDLE);
    assign accept      = pixel_valid && !pixel_stall;
    assign col_addr_b  = col_pos_reg + COL_W'(1);

    gmq_line_mem u_mem (
        .clk     (clk),
        .we      (state_reg == AS_MUL),
        .waddr   (col_pos_reg),
        .wdata   (x_reg),
        .raddr_a (col_pos_reg),
        .raddr_b (col_addr_b),
        .rdata_a (up_cell),
        .rdata_b (upright_cell)
    );

    assign c_gt0    = (col_pos_reg != '0);
    assign r_gt0    = (row_pos_reg != '0);
    assign last_col = (CFG_W'(col_pos_reg) + CFG_W'(1)) >= col_cnt_reg;
    assign last_row = (CFG_W'(row_pos_reg) + CFG_W'(1)) >= row_cnt_reg;
    assign has_ur   = r_gt0 && !last_col;

    always_comb
    begin
        nsum  = '0;
        k_cnt = '0;
        if (c_gt0)
        begin
            nsum  = nsum + NSUM_W'(left_reg);
            k_cnt = k_cnt + K_W'(1);
        end
        if (r_gt0)
        begin
            nsum  = nsum + NSUM_W'(up_cell);
            k_cnt = k_cnt + K_W'(1);
        end
        if (r_gt0 && c_gt0)
        begin
            nsum  = nsum + NSUM_W'(upleft_reg);
            k_cnt = k_cnt + K_W'(1);
        end
        if (has_ur)
        begin
            nsum  = nsum + NSUM_W'(upright_cell);
            k_cnt = k_cnt + K_W'(1);
        end
    end

    // Each pair adds both cells to T once, so T grows by k*x plus the neighbor sum.
    assign kx = x_reg * $signed({1'b0, k_reg});

    always_comb
    begin
        sums_next.s = s_reg + S_W'(x_reg);
        sums_next.q = q_reg + Q_W'($unsigned(prod_q_reg));
        sums_next.p = p_reg + (P_W'(prod_p_reg) <<< 1);
        sums_next.t = t_reg + T_W'(kx) + T_W'(nsum_reg);
        sums_next.w = w_reg + W_W'({k_reg, 1'b0});
        sums_next.n = N_W'(row_cnt_reg) * N_W'(col_cnt_reg);
    end

    assign last_cell = last_col_reg && last_row;
    assign fin_start = (state_reg == AS_ACC) && last_cell;
    assign fin_sums  = sums_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AS_IDLE:
            begin
                if (accept)
                begin
                    state_next = AS_MUL;
                end
            end
            AS_MUL:
            begin
                state_next = AS_ACC;
            end
            AS_ACC:
            begin
                state_next = last_cell ? AS_WAIT : AS_IDLE;
            end
            AS_WAIT:
            begin
                if (!fin_busy)
                begin
                    state_next = AS_IDLE;
                end
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= AS_IDLE;
            row_cnt_reg <= CFG_W'(MAX_ROWS);
            col_cnt_reg <= CFG_W'(MAX_COLS);
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            s_reg       <= '0;
            q_reg       <= '0;
            p_reg       <= '0;
            t_reg       <= '0;
            w_reg       <= '0;
            left_reg    <= '0;
            upleft_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_cnt_reg <= clamp_count(cfg_data, CFG_W'(MAX_ROWS));
                REG_COL_COUNT: col_cnt_reg <= clamp_count(cfg_data, CFG_W'(MAX_COLS));
                default:       row_cnt_reg <= row_cnt_reg;
            endcase
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            s_reg       <= '0;
            q_reg       <= '0;
            p_reg       <= '0;
            t_reg       <= '0;
            w_reg       <= '0;
            left_reg    <= '0;
            upleft_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == AS_MUL)
            begin
                upleft_reg <= up_cell;
                left_reg   <= x_reg;
            end
            if (state_reg == AS_ACC)
            begin
                if (last_cell)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= '0;
                    s_reg       <= '0;
                    q_reg       <= '0;
                    p_reg       <= '0;
                    t_reg       <= '0;
                    w_reg       <= '0;
                    left_reg    <= '0;
                    upleft_reg  <= '0;
                end
                else
                begin
                    s_reg <= sums_next.s;
                    q_reg <= sums_next.q;
                    p_reg <= sums_next.p;
                    t_reg <= sums_next.t;
                    w_reg <= sums_next.w;
                    if (last_col_reg)
                    begin
                        col_pos_reg <= '0;
                        row_pos_reg <= row_pos_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_pos_reg <= col_pos_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= pixel;
        end
        if (state_reg == AS_MUL)
        begin
            prod_p_reg   <= PP_W'(x_reg) * PP_W'(nsum);
            prod_q_reg   <= PQ_W'(x_reg) * PQ_W'(x_reg);
            nsum_reg     <= nsum;
            k_reg        <= k_cnt;
            last_col_reg <= last_col;
        end
    end

endmodule

`default_nettype wire

/* rtl/gmq_smul.sv */
// Shift-and-add multiplier: one multiplier bit per cycle.
`default_nettype none

module gmq_smul
    import gmq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [BIG_W-1:0] a,
    input  wire logic [MB_W-1:0]  b,
    output logic                  done,
    output logic [BIG_W-1:0]      product
);

    localparam int CNT_W = $clog2(MB_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [BIG_W-1:0] acc_reg, a_reg;
    logic [MB_W-1:0]  b_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(MB_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

`default_nettype wire

/* rtl/gmq_finish.sv */
// End-of-frame sequencer: exact numerator and denominator, then restoring division.
`default_nettype none

module gmq_finish
    import gmq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire gmq_sums_t        sums,
    input  wire logic             out_free,
    output logic                  busy,
    output logic                  done,
    output logic [RES_W-1:0]      moran,
    output logic                  flag
);

    localparam int DCNT_W = $clog2(DIV_W + 1);

    typedef enum logic [11:0] {
        FS_IDLE = 12'b000000000001,
        FS_NQ   = 12'b000000000010,
        FS_S2   = 12'b000000000100,
        FS_CHK  = 12'b000000001000,
        FS_DEN  = 12'b000000010000,
        FS_A1   = 12'b000000100000,
        FS_A2   = 12'b000001000000,
        FS_B1   = 12'b000010000000,
        FS_B2   = 12'b000100000000,
        FS_C    = 12'b001000000000,
        FS_DIV  = 12'b010000000000,
        FS_DONE = 12'b100000000000
    } fin_state_t;

    fin_state_t state_reg, state_next;

    logic [S_W-1:0]   s_mag_reg;
    logic [P_W-1:0]   p_mag_reg;
    logic [T_W-1:0]   t_mag_reg;
    logic             s_neg_reg, p_neg_reg, t_neg_reg;
    logic [W_W-1:0]   w_reg;
    logic [N_W-1:0]   n_reg;
    logic [BIG_W-1:0] nq_reg, s2_reg, den_reg, a_reg, b_reg, rem_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg, neg_reg, flag_reg;
    logic [DCNT_W-1:0] cnt_reg;

    logic             mul_start, mul_done;
    logic [BIG_W-1:0] mul_a, mul_prod;
    logic [MB_W-1:0]  mul_b;

    logic [BIG_W-1:0] den0;
    logic             undef;
    logic signed [BIG_W-1:0] num;
    logic [BIG_W-1:0] num_mag;
    logic [BIG_W:0]   rem_sh;
    logic             ge;
    logic             q_big;
    logic [RES_W-1:0] q_lo, res;

    gmq_smul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign den0  = nq_reg - s2_reg;
    assign undef = (w_reg == '0) || (den0 == '0);

    // The 2NST term is subtracted, so it is negative when S and T share a sign.
    always_comb
    begin
        num = mul_prod;
        num = p_neg_reg ? (num - $signed(a_reg)) : (num + $signed(a_reg));
        num = (s_neg_reg == t_neg_reg) ? (num - $signed(b_reg)) : (num + $signed(b_reg));
        num_mag = num[BIG_W-1] ? BIG_W'(-num) : BIG_W'(num);
    end

    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    mul_start  = 1'b1;
                    mul_a      = BIG_W'(sums.q);
                    mul_b      = MB_W'(sums.n);
                    state_next = FS_NQ;
                end
            end
            FS_NQ:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = BIG_W'(s_mag_reg);
                    mul_b      = MB_W'(s_mag_reg);
                    state_next = FS_S2;
                end
            end
            FS_S2:
            begin
                if (mul_done)
                begin
                    state_next = FS_CHK;
                end
            end
            FS_CHK:
            begin
                if (undef)
                begin
                    state_next = FS_DONE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = den0;
                    mul_b      = MB_W'(w_reg);
                    state_next = FS_DEN;
                end
            end
            FS_DEN:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = BIG_W'(p_mag_reg);
                    mul_b      = MB_W'(n_reg);
                    state_next = FS_A1;
                end
            end
            FS_A1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = MB_W'(n_reg);
                    state_next = FS_A2;
                end
            end
            FS_A2:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = BIG_W'(s_mag_reg);
                    mul_b      = MB_W'(t_mag_reg);
                    state_next = FS_B1;
                end
            end
            FS_B1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = MB_W'({n_reg, 1'b0});
                    state_next = FS_B2;
                end
            end
            FS_B2:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = s2_reg;
                    mul_b      = MB_W'(w_reg);
                    state_next = FS_C;
                end
            end
            FS_C:
            begin
                if (mul_done)
                begin
                    state_next = FS_DIV;
                end
            end
            FS_DIV:
            begin
                if (cnt_reg == DCNT_W'(1))
                begin
                    state_next = FS_DONE;
                end
            end
            FS_DONE:
            begin
                if (out_free)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FS_C && mul_done)
            begin
                cnt_reg <= DCNT_W'(DIV_W);
            end
            else if (state_reg == FS_DIV)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    s_neg_reg <= sums.s[S_W-1];
                    s_mag_reg <= sums.s[S_W-1] ? S_W'(-sums.s) : S_W'(sums.s);
                    p_neg_reg <= sums.p[P_W-1];
                    p_mag_reg <= sums.p[P_W-1] ? P_W'(-sums.p) : P_W'(sums.p);
                    t_neg_reg <= sums.t[T_W-1];
                    t_mag_reg <= sums.t[T_W-1] ? T_W'(-sums.t) : T_W'(sums.t);
                    w_reg     <= sums.w;
                    n_reg     <= sums.n;
                    flag_reg  <= 1'b0;
                end
            end
            FS_NQ:
            begin
                if (mul_done)
                begin
                    nq_reg <= mul_prod;
                end
            end
            FS_S2:
            begin
                if (mul_done)
                begin
                    s2_reg <= mul_prod;
                end
            end
            FS_CHK:
            begin
                if (undef)
                begin
                    flag_reg <= 1'b1;
                end
            end
            FS_DEN:
            begin
                if (mul_done)
                begin
                    den_reg <= mul_prod;
                end
            end
            FS_A2:
            begin
                if (mul_done)
                begin
                    a_reg <= mul_prod;
                end
            end
            FS_B2:
            begin
                if (mul_done)
                begin
                    b_reg <= mul_prod;
                end
            end
            FS_C:
            begin
                if (mul_done)
                begin
                    neg_reg <= num[BIG_W-1];
                    dvd_reg <= {num_mag, FRAC_W'(0)};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end
            FS_DIV:
            begin
                rem_reg <= ge ? BIG_W'(rem_sh - {1'b0, den_reg}) : BIG_W'(rem_sh);
                dvd_reg <= dvd_reg << 1;
                ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // Quotients past 32 bits leave a sticky overflow and saturate either way.
    assign q_big = ovf_reg || quo_reg[QUO_W-1];
    assign q_lo  = quo_reg[RES_W-1:0];

    always_comb
    begin
        if (!neg_reg)
        begin
            res = (q_big || q_lo[RES_W-1]) ? RES_POS_MAX : q_lo;
        end
        else
        begin
            res = (q_big || q_lo > RES_NEG_MIN) ? RES_NEG_MIN : RES_W'(-q_lo);
        end
    end

    assign busy  = (state_reg != FS_IDLE);
    assign done  = (state_reg == FS_DONE);
    assign flag  = flag_reg;
    assign moran = flag_reg ? '0 : res;

endmodule

`default_nettype wire
